[design/pdrc_pkg.sv]
// Shared types, constants and the checksum step for the packet deframer.
// Used by pdrc_front, pdrc_desc_fifo, pdrc_back and the top level.
package pdrc_pkg;

    // Reset value of the start-of-frame byte
    localparam logic [7:0] START_RESET = 8'd204;
    // Default largest payload in bytes (1 to 63)
    localparam int MAX_PAYLOAD_DEF = 32;
    // Width of a payload length or index; holds any length up to 63
    localparam int LEN_W = 6;
    // Accepted frames that may wait for the drain side (one payload buffer each)
    localparam int DESC_DEPTH = 2;
    localparam int DESC_CNT_W = $clog2(DESC_DEPTH + 1);

    // Descriptor of an accepted frame, handed from front to back
    typedef struct packed {
        logic [7:0]       id;
        logic [LEN_W-1:0] len;
        logic             bsel;
    } t_desc;

    // Payload memory write from the front
    typedef struct packed {
        logic             en;
        logic             bsel;
        logic [LEN_W-1:0] idx;
        logic [7:0]       data;
    } t_wr;

    // One checksum step: rotate right by one, then add the byte
    function automatic logic [7:0] sum_step(input logic [7:0] sum, input logic [7:0] b);
        logic [7:0] rot;
        rot = {sum[0], sum[7:1]};
        return rot + b;
    endfunction

endpackage

[design/packet_deframer_rotating_checksum.sv]
// Packet deframer with rotating 8-bit checksum, top level.
// Instantiates pdrc_front, pdrc_desc_fifo and pdrc_back; uses pdrc_pkg.
//
// Usage:
//   Slave stream carries one received byte per word. Frames are: start byte,
//   length (ID plus payload), ID, payload, unchecked tail, checksum. The start
//   byte is set through i_cfg_wr_en / i_cfg_wr_data (reset value 204).
//   Master stream gives the ID (tuser high) then the payload bytes, tlast on
//   the final word; frames with a bad checksum or oversize length give nothing.
// Throughput: one input word per cycle; the drain side gives one output word
//   per cycle, set by the single read port of the payload buffers.
// Output path: with the drain side idle, the descriptor is queued at the edge
//   that accepts the checksum word, and the output register is then loaded
//   with the ID.
// Stalls: two accepted frames may wait to drain, each in its own payload
//   buffer; while both are held, s_axis_tready is low. A stalled receiver
//   holds the output register and stops the drain.
// Reset: synchronous, active low; parser waits for a start byte, the queue
//   empties and the start byte returns to 204. Payload buffers need no clearing.
module packet_deframer_rotating_checksum #(
    parameter int MAX_PAYLOAD = pdrc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data
    output logic       m_axis_tuser,   // [0] is_id
    output logic       m_axis_tlast
);

    logic            fifo_full;
    logic            fifo_empty;
    logic            push;
    logic            pop;
    pdrc_pkg::t_desc desc_in;
    pdrc_pkg::t_desc desc_head;
    pdrc_pkg::t_wr   wr;

    pdrc_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_byte        (s_axis_tdata),
        .i_fifo_full   (fifo_full),
        .o_push        (push),
        .o_desc        (desc_in),
        .o_wr          (wr)
    );

    pdrc_desc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc_in),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_empty (fifo_empty),
        .o_head  (desc_head)
    );

    pdrc_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_head_vld (!fifo_empty),
        .i_head     (desc_head),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_is_id    (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

endmodule

[design/pdrc_front.sv]
// Front side of the deframer: parses received words, runs the checksum,
// writes payload bytes and queues a descriptor per good frame. Uses pdrc_pkg.
module pdrc_front #(
    parameter int MAX_PAYLOAD = pdrc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte,
    input  logic                i_fifo_full,
    output logic                o_push,
    output pdrc_pkg::t_desc     o_desc,
    output pdrc_pkg::t_wr       o_wr
);

    localparam logic [7:0] LEN_LIMIT = 8'(MAX_PAYLOAD + 1);

    typedef enum logic [3:0] {
        FR_WAIT  = 4'b0001,
        FR_LEN   = 4'b0010,
        FR_BODY  = 4'b0100,
        FR_CHECK = 4'b1000
    } t_fr_state;

    t_fr_state                  r_state, n_state;
    logic [7:0]                 r_start_byte;
    logic [pdrc_pkg::LEN_W-1:0] r_len, n_len;
    logic [pdrc_pkg::LEN_W-1:0] r_count, n_count;
    logic                       r_id_seen, n_id_seen;
    logic [7:0]                 r_frame_id, n_frame_id;
    logic [7:0]                 r_sum, n_sum;
    logic                       r_wr_sel, n_wr_sel;
    logic                       accept;

    // Stall while both payload buffers wait to be drained
    assign o_ready = !i_fifo_full;
    assign accept  = i_valid && o_ready;

    assign o_desc.id   = r_frame_id;
    assign o_desc.len  = r_len;
    assign o_desc.bsel = r_wr_sel;

    // Parse one word
    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_count    = r_count;
        n_id_seen  = r_id_seen;
        n_frame_id = r_frame_id;
        n_sum      = r_sum;
        n_wr_sel   = r_wr_sel;
        o_push     = 1'b0;
        o_wr.en    = 1'b0;
        o_wr.bsel  = r_wr_sel;
        o_wr.idx   = r_count;
        o_wr.data  = i_byte;
        if (accept) begin
            unique case (r_state)
                FR_WAIT: begin
                    if (i_byte == r_start_byte) begin
                        n_sum     = '0;
                        n_id_seen = 1'b0;
                        n_count   = '0;
                        n_state   = FR_LEN;
                    end
                end
                FR_LEN: begin
                    // Length zero behaves as an ID-only frame
                    n_len = (i_byte == 8'd0) ? '0 : pdrc_pkg::LEN_W'(i_byte - 8'd1);
                    n_state = (i_byte > LEN_LIMIT) ? FR_WAIT : FR_BODY;
                end
                FR_BODY: begin
                    if (!r_id_seen) begin
                        n_frame_id = i_byte;
                        n_id_seen  = 1'b1;
                        n_sum      = pdrc_pkg::sum_step(r_sum, i_byte);
                    end else if (r_count >= r_len) begin
                        // Tail word, not checked
                        n_count   = '0;
                        n_id_seen = 1'b0;
                        n_state   = FR_CHECK;
                    end else begin
                        o_wr.en = 1'b1;
                        n_count = r_count + 1'b1;
                        n_sum   = pdrc_pkg::sum_step(r_sum, i_byte);
                    end
                end
                FR_CHECK: begin
                    if (r_sum == i_byte) begin
                        o_push   = 1'b1;
                        n_wr_sel = !r_wr_sel;
                        n_sum    = '0;
                    end
                    n_state = FR_WAIT;
                end
                default: n_state = FR_WAIT;
            endcase
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= FR_WAIT;
            r_start_byte <= pdrc_pkg::START_RESET;
            r_count      <= '0;
            r_id_seen    <= 1'b0;
            r_sum        <= '0;
            r_wr_sel     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_id_seen <= n_id_seen;
            r_sum     <= n_sum;
            r_wr_sel  <= n_wr_sel;
            if (i_cfg_wr_en) begin
                r_start_byte <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_frame_id <= n_frame_id;
    end

endmodule

[design/pdrc_desc_fifo.sv]
// Short descriptor queue between the parsing front and the draining back.
// Uses pdrc_pkg for the descriptor type and depth.
module pdrc_desc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pdrc_pkg::t_desc i_desc,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output pdrc_pkg::t_desc o_head
);

    localparam int PTR_W = $clog2(pdrc_pkg::DESC_DEPTH);

    pdrc_pkg::t_desc                r_mem [pdrc_pkg::DESC_DEPTH];
    logic [PTR_W-1:0]               r_wr_ptr, r_rd_ptr;
    logic [pdrc_pkg::DESC_CNT_W-1:0] r_count;

    assign o_full  = (r_count == pdrc_pkg::DESC_CNT_W'(pdrc_pkg::DESC_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("descriptor pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("descriptor popped from empty queue");

endmodule

[design/pdrc_back.sv]
// Back side of the deframer: holds the two payload buffers and drains one
// accepted frame at a time onto the output register. Uses pdrc_pkg.
module pdrc_back #(
    parameter int MAX_PAYLOAD = pdrc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pdrc_pkg::t_wr   i_wr,
    input  logic            i_head_vld,
    input  pdrc_pkg::t_desc i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_data,
    output logic            o_is_id,
    output logic            o_last
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int DEPTH = 2 ** (IDX_W + 1);

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_DATA = 2'b10
    } t_bk_state;

    logic [7:0]                 r_mem [DEPTH];
    logic [7:0]                 r_rd_data;
    logic                       rd_en;
    logic [IDX_W:0]             rd_addr;
    t_bk_state                  r_state, n_state;
    logic [pdrc_pkg::LEN_W-1:0] r_idx, n_idx;
    logic                       r_valid, n_valid;
    logic [7:0]                 r_data, n_data;
    logic                       r_is_id, n_is_id;
    logic                       r_last, n_last;
    logic                       slot_free;

    assign o_valid   = r_valid;
    assign o_data    = r_data;
    assign o_is_id   = r_is_id;
    assign o_last    = r_last;
    assign slot_free = !r_valid || i_ready;

    // Payload buffers: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bsel, i_wr.idx[IDX_W-1:0]}] <= i_wr.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Drain sequencer
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_valid = r_valid && !i_ready;
        n_data  = r_data;
        n_is_id = r_is_id;
        n_last  = r_last;
        o_pop   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = {i_head.bsel, r_idx[IDX_W-1:0]};
        unique case (r_state)
            BK_IDLE: begin
                if (i_head_vld && slot_free) begin
                    n_valid = 1'b1;
                    n_data  = i_head.id;
                    n_is_id = 1'b1;
                    n_last  = (i_head.len == '0);
                    if (i_head.len == '0) begin
                        o_pop = 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = {i_head.bsel, {IDX_W{1'b0}}};
                        n_idx   = pdrc_pkg::LEN_W'(1);
                        n_state = BK_DATA;
                    end
                end
            end
            BK_DATA: begin
                // Read data for the word before r_idx is waiting
                if (slot_free) begin
                    n_valid = 1'b1;
                    n_data  = r_rd_data;
                    n_is_id = 1'b0;
                    n_last  = (r_idx == i_head.len);
                    if (r_idx == i_head.len) begin
                        o_pop   = 1'b1;
                        n_state = BK_IDLE;
                    end else begin
                        rd_en = 1'b1;
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_is_id <= n_is_id;
        r_last  <= n_last;
    end

    a_drain_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DATA) |-> i_head_vld) else $error("draining without descriptor");
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DATA) |-> (r_idx != '0 && r_idx <= i_head.len))
        else $error("drain index out of range");
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_last)) else $error("frame released without last word");

endmodule

[tb/tb_packet_deframer_rotating_checksum.sv]
`timescale 1ns / 1ps
// Self-checking testbench for packet_deframer_rotating_checksum: builds frames, predicts
// the deframed words and checks the master stream. Depends on pdrc_pkg and the top level.
module tb_packet_deframer_rotating_checksum;

    localparam int MAX_PAYLOAD = pdrc_pkg::MAX_PAYLOAD_DEF;
    localparam int STORE_AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_PAUSE = 8;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_LEN,
        PH_BODY,
        PH_CHECK
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       is_id;
        logic       last;
    } t_deframed_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] rx_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] data
    logic       m_axis_tuser;   // [0] is_id
    logic       m_axis_tlast;

    // Predicted parser state
    t_parse_phase rx_phase;
    logic [7:0]   rx_len;
    logic         rx_id_seen;
    logic [7:0]   rx_id;
    logic [5:0]   rx_count;
    logic [7:0]   rx_sum;
    logic [7:0]   rx_store [MAX_PAYLOAD];
    logic [7:0]   start_cfg;

    t_deframed_word words_due[$];
    logic [7:0]     frame_body[$];

    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned stim_words;
    int unsigned noise_words;
    bit          quiet_in;
    bit          quiet_out;

    packet_deframer_rotating_checksum #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Rotate the running sum right by one, then add the byte
    function automatic logic [7:0] fold_byte(input logic [7:0] sum, input logic [7:0] b);
        logic [7:0] turned;
        turned = {sum[0], sum[7:1]};
        return 8'(turned + b);
    endfunction

    // Advance the predicted parser by one accepted byte and queue any deframed words
    task automatic deframe_byte(input logic [7:0] b);
        int             n_pay;
        t_deframed_word w;
        n_pay = (rx_len == 8'd0) ? 0 : int'(rx_len) - 1;
        case (rx_phase)
            PH_WAIT: begin
                if (b == start_cfg) begin
                    rx_sum     = 8'd0;
                    rx_id_seen = 1'b0;
                    rx_count   = 6'd0;
                    rx_phase   = PH_LEN;
                end
            end
            PH_LEN: begin
                rx_len   = b;
                rx_phase = (int'(b) > MAX_PAYLOAD + 1) ? PH_WAIT : PH_BODY;
            end
            PH_BODY: begin
                if (!rx_id_seen) begin
                    rx_id      = b;
                    rx_id_seen = 1'b1;
                    rx_sum     = fold_byte(rx_sum, b);
                end else if (int'(rx_count) >= n_pay) begin
                    // tail byte carries nothing
                    rx_count   = 6'd0;
                    rx_id_seen = 1'b0;
                    rx_phase   = PH_CHECK;
                end else begin
                    if (int'(rx_count) < MAX_PAYLOAD) rx_store[rx_count[STORE_AW-1:0]] = b;
                    rx_count = rx_count + 6'd1;
                    rx_sum   = fold_byte(rx_sum, b);
                end
            end
            PH_CHECK: begin
                if (rx_sum == b) begin
                    w.data  = rx_id;
                    w.is_id = 1'b1;
                    w.last  = (n_pay == 0);
                    words_due.push_back(w);
                    for (int i = 0; i < n_pay; i++) begin
                        w.data  = rx_store[i];
                        w.is_id = 1'b0;
                        w.last  = (i + 1 == n_pay);
                        words_due.push_back(w);
                    end
                    rx_sum = 8'd0;
                end
                rx_phase = PH_WAIT;
            end
        endcase
    endtask

    // Present one byte on the slave stream after a random gap, hold until taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        stim_words++;
        deframe_byte(b);
    endtask

    // Send a whole frame around frame_body; corrupt spoils the checksum
    task automatic send_frame(input logic [7:0] id, input bit zero_len, input logic [7:0] tail,
                              input bit corrupt);
        logic [7:0] sum;
        logic [7:0] len_b;
        sum = fold_byte(8'd0, id);
        foreach (frame_body[i]) sum = fold_byte(sum, frame_body[i]);
        if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
        len_b = zero_len ? 8'd0 : 8'(frame_body.size() + 1);
        send_byte(start_cfg);
        send_byte(len_b);
        send_byte(id);
        foreach (frame_body[i]) send_byte(frame_body[i]);
        send_byte(tail);
        send_byte(sum);
    endtask

    task automatic fill_body(input int n);
        frame_body.delete();
        repeat (n) frame_body.push_back(8'($urandom_range(0, 255)));
    endtask

    // Feed filler until the parser is back waiting for a start byte
    task automatic resync();
        while (rx_phase != PH_WAIT) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Change the start byte once the block has drained
    task automatic set_start(input logic [7:0] value);
        resync();
        s_axis_tvalid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        start_cfg = value;
    endtask

    // Frames that carry only an ID, with zero and one as the length
    task automatic test_id_only_frames();
        fill_body(0);
        send_frame(8'h00, 1'b1, 8'hFF, 1'b0);
        send_frame(8'hFF, 1'b0, 8'h00, 1'b0);
    endtask

    // Lengths beyond the payload limit drop the frame
    task automatic test_oversize_length();
        send_byte(start_cfg);
        send_byte(8'(MAX_PAYLOAD + 2));
        send_byte(start_cfg);
        send_byte(8'hFF);
    endtask

    task automatic test_bad_checksum();
        frame_body.delete();
        frame_body.push_back(8'hFF);
        send_frame(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Start byte as ID, payload and tail is plain data
    task automatic test_start_inside_frame();
        frame_body.delete();
        frame_body.push_back(start_cfg);
        send_frame(start_cfg, 1'b0, start_cfg, 1'b0);
    endtask

    task automatic test_start_byte_extremes();
        set_start(8'h00);
        fill_body(3);
        send_frame(8'($urandom_range(0, 255)), 1'b0, 8'h00, 1'b0);
        set_start(8'hFF);
        fill_body(2);
        send_frame(8'($urandom_range(0, 255)), 1'b0, 8'hFF, 1'b0);
    endtask

    // Largest payload, once with gaps and once back to back
    task automatic test_max_payload();
        fill_body(MAX_PAYLOAD);
        send_frame(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)), 1'b0);
        quiet_in = 1'b1;
        fill_body(MAX_PAYLOAD);
        send_frame(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)), 1'b0);
        quiet_in = 1'b0;
    endtask

    // Mostly good frames with random content, mixed with broken ones and noise
    task automatic test_random_traffic(input int unsigned n_words);
        int unsigned first;
        int          kind;
        int          n;
        int          cut;
        logic [7:0]  b;
        first = stim_words - noise_words;
        while (stim_words - noise_words - first < n_words) begin
            kind     = $urandom_range(0, 99);
            quiet_in = ($urandom_range(0, 3) == 0);
            n        = $urandom_range(0, 19);
            if (n == 0) n = MAX_PAYLOAD;
            else if (n < 3) n = $urandom_range(9, MAX_PAYLOAD - 1);
            else n = $urandom_range(0, 8);
            fill_body(n);
            if (kind < 65) begin
                send_frame(8'($urandom_range(0, 255)), (n == 0) && ($urandom_range(0, 1) == 1),
                           8'($urandom_range(0, 255)), 1'b0);
            end else if (kind < 75) begin
                send_frame(8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)), 1'b1);
            end else if (kind < 82) begin
                send_byte(start_cfg);
                send_byte(8'($urandom_range(MAX_PAYLOAD + 2, 255)));
            end else if (kind < 90) begin
                // cut the frame short, then let filler close it
                cut = $urandom_range(0, n);
                send_byte(start_cfg);
                send_byte(8'(n + 1));
                send_byte(8'($urandom_range(0, 255)));
                for (int i = 0; i < cut; i++) send_byte(frame_body[i]);
                resync();
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    do b = 8'($urandom_range(0, 255)); while (b == start_cfg);
                    send_byte(b);
                    noise_words++;
                end
            end
        end
        quiet_in = 1'b0;
    endtask

    // Master side: random stalls, check each word against the oldest prediction
    initial begin
        int             stall;
        t_deframed_word want;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if ($urandom_range(0, 15) == 0) quiet_out = ~quiet_out;
            stall = quiet_out ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            if (words_due.size() == 0) begin
                $display("%0t: unexpected word, expected none, got data %02h is_id %0b last %0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fail_count++;
            end else begin
                want = words_due.pop_front();
                if (m_axis_tdata !== want.data) begin
                    $display("%0t: data mismatch, expected %02h, got %02h",
                             $time, want.data, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tuser !== want.is_id) begin
                    $display("%0t: is_id mismatch, expected %0b, got %0b",
                             $time, want.is_id, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last mismatch, expected %0b, got %0b",
                             $time, want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 8'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        fail_count  = 0;
        cycle_count = 0;
        stim_words  = 0;
        noise_words = 0;
        quiet_in    = 1'b0;
        quiet_out   = 1'b0;
        rx_phase    = PH_WAIT;
        rx_len      = 8'd0;
        rx_id_seen  = 1'b0;
        rx_id       = 8'd0;
        rx_count    = 6'd0;
        rx_sum      = 8'd0;
        start_cfg   = pdrc_pkg::START_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_id_only_frames();
        test_oversize_length();
        test_bad_checksum();
        test_start_inside_frame();
        test_start_byte_extremes();
        test_max_payload();
        test_random_traffic(6);
        set_start(8'($urandom_range(0, 255)));
        test_random_traffic(6);
        set_start(pdrc_pkg::START_RESET);
        test_random_traffic(6);

        // Drain and let the pipeline settle
        s_axis_tvalid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
design/pdrc_pkg.sv
design/pdrc_front.sv
design/pdrc_desc_fifo.sv
design/pdrc_back.sv
design/packet_deframer_rotating_checksum.sv
tb/tb_packet_deframer_rotating_checksum.sv
